>>> sv/zbtsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package zbtsc_pkg;

    // action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_DRAW  = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_CENTER_ROW = 2'd0;
    localparam logic [1:0] CFG_SCALE_Q16  = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND = 2'd2;

    localparam int ROW_W  = 11;  // holds any clipped row up to the tallest column
    localparam int ACC_W  = 42;  // u and depth accumulators, signed 26.16
    localparam int STEP_W = 28;  // per-row increments

    localparam logic signed [ACC_W-1:0] DEPTH_MIN = -ACC_W'(64'h7fffffff);

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         index;
        logic [15:0]        texel_value;
        logic signed [23:0] start_x;
        logic signed [23:0] start_z;
        logic [9:0]         start_u;
        logic signed [23:0] end_x;
        logic signed [23:0] end_z;
        logic [9:0]         end_u;
    } item_t;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic        covered;
    } result_t;

    typedef struct packed {
        logic [7:0]  center_row;
        logic [19:0] scale_q16;
        logic [15:0] background_color;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                op;
        logic [7:0]                index;
        logic [15:0]               texel;
        logic [ROW_W-1:0]          row_start;
        logic [ROW_W-1:0]          row_end;
        logic signed [ACC_W-1:0]   su;
        logic signed [ACC_W-1:0]   sz;
        logic signed [STEP_W-1:0]  stepu;
        logic signed [STEP_W-1:0]  stepz;
    } cmd_t;

endpackage
`default_nettype wire

>>> sv/zbtsc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module zbtsc_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire T     wr_data,
    output logic      full,
    input  wire logic rd_en,
    output T          rd_data,
    output logic      empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              store_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/zbtsc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module zbtsc_front #(
    parameter int COLUMN_HEIGHT = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire zbtsc_pkg::item_t item,
    input  wire zbtsc_pkg::cfg_t  cfg,
    input  wire logic             init_busy,
    output logic                  cmd_valid,
    output zbtsc_pkg::cmd_t       cmd,
    input  wire logic             cmd_full
);
    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL  = 6'b000010,
        F_CLIP = 6'b000100,
        F_DIV  = 6'b001000,
        F_OFFS = 6'b010000,
        F_PUSH = 6'b100000
    } front_state_t;

    localparam logic signed [13:0] HEIGHT_S = 14'(COLUMN_HEIGHT);
    localparam int STEP_W_L = zbtsc_pkg::STEP_W;

    front_state_t            state_reg, state_next;
    zbtsc_pkg::item_t        item_reg, item_next;
    zbtsc_pkg::cmd_t         cmd_reg, cmd_next;
    logic signed [44:0]      pa_reg, pa_next, pb_reg, pb_next;
    logic signed [13:0]      r1_reg, r1_next;
    logic [13:0]             dr_reg, dr_next;
    logic [26:0]             qu_reg, qu_next, qz_reg, qz_next;
    logic [13:0]             remu_reg, remu_next, remz_reg, remz_next;
    logic                    negu_reg, negu_next, negz_reg, negz_next;
    logic [4:0]              cnt_reg, cnt_next;

    logic                    accept;
    logic signed [13:0]      r1, r2, r1c, r2c;
    logic signed [10:0]      du, dz;
    logic signed [9:0]       z1, z2;
    logic [10:0]             du_mag, dz_mag;
    logic [14:0]             tu, tz;
    logic signed [STEP_W_L-1:0] stepu, stepz;
    logic [12:0]             lead;
    logic signed [zbtsc_pkg::ACC_W-1:0] offu, offz;

    assign full      = (state_reg != F_IDLE) || init_busy;
    assign accept    = push && !full;
    assign cmd_valid = (state_reg == F_PUSH);
    assign cmd       = cmd_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        cmd_next   = cmd_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        r1_next    = r1_reg;
        dr_next    = dr_reg;
        qu_next    = qu_reg;
        qz_next    = qz_reg;
        remu_next  = remu_reg;
        remz_next  = remz_reg;
        negu_next  = negu_reg;
        negz_next  = negz_reg;
        cnt_next   = cnt_reg;

        r1   = 14'($signed(pa_reg[44:32])) + $signed({6'b0, cfg.center_row});
        r2   = 14'($signed(pb_reg[44:32])) + $signed({6'b0, cfg.center_row});
        r1c  = (r1 < 0) ? 14'sd0 : r1;
        r2c  = (r2 > HEIGHT_S) ? HEIGHT_S : r2;
        du   = $signed({1'b0, item_reg.end_u}) - $signed({1'b0, item_reg.start_u});
        z1   = item_reg.start_z[23:14];
        z2   = item_reg.end_z[23:14];
        dz   = 11'(z2) - 11'(z1);
        du_mag = du[10] ? 11'(-du) : 11'(du);
        dz_mag = dz[10] ? 11'(-dz) : 11'(dz);
        tu   = {remu_reg, qu_reg[26]};
        tz   = {remz_reg, qz_reg[26]};
        stepu = negu_reg ? -$signed({1'b0, qu_reg}) : $signed({1'b0, qu_reg});
        stepz = negz_reg ? -$signed({1'b0, qz_reg}) : $signed({1'b0, qz_reg});
        lead  = 13'(-r1_reg);
        offu  = (r1_reg < 0) ? (zbtsc_pkg::ACC_W'(stepu)
                                * zbtsc_pkg::ACC_W'($signed({1'b0, lead}))) : '0;
        offz  = (r1_reg < 0) ? (zbtsc_pkg::ACC_W'(stepz)
                                * zbtsc_pkg::ACC_W'($signed({1'b0, lead}))) : '0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    item_next      = item;
                    cmd_next.op    = item.action;
                    cmd_next.index = item.index;
                    cmd_next.texel = item.texel_value;
                    if (item.action == zbtsc_pkg::ACT_DRAW)
                    begin
                        // a segment with no forward extent draws nothing
                        if (item.end_x > item.start_x)
                        begin
                            state_next = F_MUL;
                        end
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_MUL:
            begin
                pa_next    = item_reg.start_x * $signed({1'b0, cfg.scale_q16});
                pb_next    = item_reg.end_x * $signed({1'b0, cfg.scale_q16});
                state_next = F_CLIP;
            end
            F_CLIP:
            begin
                if (r2c > r1c)
                begin
                    r1_next   = r1;
                    dr_next   = 14'(r2 - r1);
                    qz_next   = {dz_mag, 16'b0};
                    qu_next   = {du_mag, 16'b0};
                    negu_next = du[10];
                    negz_next = dz[10];
                    remu_next = '0;
                    remz_next = '0;
                    cnt_next  = 5'd26;
                    cmd_next.row_start = zbtsc_pkg::ROW_W'(r1c);
                    cmd_next.row_end   = zbtsc_pkg::ROW_W'(r2c);
                    state_next = F_DIV;
                end
                else
                begin
                    state_next = F_IDLE;
                end
            end
            F_DIV:
            begin
                // one restoring step per cycle on both quotients, shared divisor
                if (tu >= {1'b0, dr_reg})
                begin
                    remu_next = 14'(tu - {1'b0, dr_reg});
                    qu_next   = {qu_reg[25:0], 1'b1};
                end
                else
                begin
                    remu_next = tu[13:0];
                    qu_next   = {qu_reg[25:0], 1'b0};
                end
                if (tz >= {1'b0, dr_reg})
                begin
                    remz_next = 14'(tz - {1'b0, dr_reg});
                    qz_next   = {qz_reg[25:0], 1'b1};
                end
                else
                begin
                    remz_next = tz[13:0];
                    qz_next   = {qz_reg[25:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = F_OFFS;
                end
            end
            F_OFFS:
            begin
                // rows above the column are skipped by advancing the accumulators
                cmd_next.stepu = stepu;
                cmd_next.stepz = stepz;
                cmd_next.su    = $signed({16'b0, item_reg.start_u, 16'b0}) + offu;
                cmd_next.sz    = $signed({{16{z1[9]}}, z1, 16'b0}) + offz;
                state_next     = F_PUSH;
            end
            F_PUSH:
            begin
                if (!cmd_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cmd_reg  <= cmd_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        r1_reg   <= r1_next;
        dr_reg   <= dr_next;
        qu_reg   <= qu_next;
        qz_reg   <= qz_next;
        remu_reg <= remu_next;
        remz_reg <= remz_next;
        negu_reg <= negu_next;
        negz_reg <= negz_next;
        cnt_reg  <= cnt_next;
    end

endmodule
`default_nettype wire

>>> sv/zbtsc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module zbtsc_back #(
    parameter int COLUMN_HEIGHT = 256
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_empty,
    input  wire zbtsc_pkg::cmd_t cmd,
    output logic                 cmd_pop,
    input  wire logic [15:0]     background,
    input  wire logic            res_full,
    output logic                 res_push,
    output zbtsc_pkg::result_t   res_data,
    output logic                 init_busy
);
    localparam int RW  = $clog2(COLUMN_HEIGHT);
    localparam int PXW = RW + 1;
    localparam int AW  = zbtsc_pkg::ACC_W;

    typedef enum logic [6:0] {
        B_IDLE   = 7'b0000001,
        B_CLEAR  = 7'b0000010,
        B_PRD    = 7'b0000100,
        B_PSHADE = 7'b0001000,
        B_PWR    = 7'b0010000,
        B_RRD    = 7'b0100000,
        B_ROUT   = 7'b1000000
    } back_state_t;

    back_state_t              state_reg, state_next;
    logic [PXW-1:0]           px_reg, px_next, end_reg, end_next;
    logic signed [AW-1:0]     su_reg, su_next, sz_reg, sz_next;
    logic signed [zbtsc_pkg::STEP_W-1:0] stepu_reg, stepu_next, stepz_reg, stepz_next;
    logic                     init_reg, init_next, oob_reg, oob_next;
    logic [9:0]               inten_reg, inten_next;

    logic signed [AW-1:0]     depth_mem [COLUMN_HEIGHT];
    logic [15:0]              color_mem [COLUMN_HEIGHT];
    logic [15:0]              tex_mem   [256];
    logic signed [AW-1:0]     depth_q;
    logic [15:0]              color_q, tex_q;

    logic                     depth_we, color_we, tex_we;
    logic signed [AW-1:0]     depth_wd;
    logic [15:0]              color_wd;
    logic [RW-1:0]            addr;
    logic [7:0]               tex_addr;
    logic [PXW-1:0]           px_inc;
    logic signed [26:0]       ishift;
    logic [8:0]               iclamp;
    logic [17:0]              isq;
    logic [4:0]               blend_r, blend_b;
    logic [5:0]               blend_g;

    function automatic logic [5:0] blend(input logic [5:0] bg, input logic [5:0] tex,
                                         input logic [9:0] inten, input logic [5:0] maxv);
        logic signed [7:0]  diff;
        logic signed [19:0] sum;
        logic signed [11:0] sh;
        diff = $signed({2'b0, tex}) - $signed({2'b0, bg});
        sum  = $signed({6'b0, bg, 8'b0}) + (20'($signed({1'b0, inten})) * 20'(diff));
        sh   = sum[19:8];
        if (sh < 0)
        begin
            return 6'd0;
        end
        else if (sh > $signed({6'b0, maxv}))
        begin
            return maxv;
        end
        return sh[5:0];
    endfunction

    assign init_busy = init_reg;
    assign addr      = px_reg[RW-1:0];
    assign tex_addr  = su_reg[23:16];
    assign px_inc    = px_reg + 1'b1;
    assign ishift    = 27'($signed(sz_reg[AW-1:16])) + 27'sd32;
    assign iclamp    = (ishift < 0) ? 9'd0 : ((ishift > 27'sd256) ? 9'd256 : ishift[8:0]);
    assign isq       = 18'(iclamp) * 18'(iclamp);
    assign blend_b   = 5'(blend({1'b0, background[4:0]}, {1'b0, tex_q[4:0]}, inten_reg, 6'd31));
    assign blend_g   = blend(background[10:5], tex_q[10:5], inten_reg, 6'd63);
    assign blend_r   = 5'(blend({1'b0, background[15:11]}, {1'b0, tex_q[15:11]},
                                inten_reg, 6'd31));

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        end_next   = end_reg;
        su_next    = su_reg;
        sz_next    = sz_reg;
        stepu_next = stepu_reg;
        stepz_next = stepz_reg;
        init_next  = init_reg;
        oob_next   = oob_reg;
        inten_next = inten_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res_data   = '0;
        depth_we   = 1'b0;
        color_we   = 1'b0;
        tex_we     = 1'b0;
        depth_wd   = zbtsc_pkg::DEPTH_MIN;
        color_wd   = {blend_r, blend_g, blend_b};

        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        zbtsc_pkg::ACT_CLEAR:
                        begin
                            px_next    = '0;
                            state_next = B_CLEAR;
                        end
                        zbtsc_pkg::ACT_LOAD:
                        begin
                            tex_we = 1'b1;
                        end
                        zbtsc_pkg::ACT_DRAW:
                        begin
                            px_next    = PXW'(cmd.row_start);
                            end_next   = PXW'(cmd.row_end);
                            su_next    = cmd.su;
                            sz_next    = cmd.sz;
                            stepu_next = cmd.stepu;
                            stepz_next = cmd.stepz;
                            state_next = B_PRD;
                        end
                        default:
                        begin
                            px_next    = PXW'(cmd.index);
                            oob_next   = ({24'b0, cmd.index} >= 32'(COLUMN_HEIGHT));
                            state_next = B_RRD;
                        end
                    endcase
                end
            end
            B_CLEAR:
            begin
                depth_we = 1'b1;
                color_we = 1'b1;
                color_wd = init_reg ? 16'd0 : background;
                px_next  = px_inc;
                if (px_reg == PXW'(COLUMN_HEIGHT - 1))
                begin
                    init_next  = 1'b0;
                    state_next = B_IDLE;
                end
            end
            B_PRD:
            begin
                state_next = B_PSHADE;
            end
            B_PSHADE:
            begin
                inten_next = isq[16:7];
                if (sz_reg > depth_q)
                begin
                    state_next = B_PWR;
                end
                else
                begin
                    px_next    = px_inc;
                    su_next    = su_reg + AW'(stepu_reg);
                    sz_next    = sz_reg + AW'(stepz_reg);
                    state_next = (px_inc == end_reg) ? B_IDLE : B_PRD;
                end
            end
            B_PWR:
            begin
                depth_we   = 1'b1;
                color_we   = 1'b1;
                depth_wd   = sz_reg;
                px_next    = px_inc;
                su_next    = su_reg + AW'(stepu_reg);
                sz_next    = sz_reg + AW'(stepz_reg);
                state_next = (px_inc == end_reg) ? B_IDLE : B_PRD;
            end
            B_RRD:
            begin
                state_next = B_ROUT;
            end
            B_ROUT:
            begin
                if (!res_full)
                begin
                    res_push             = 1'b1;
                    res_data.pixel_color = oob_reg ? 16'd0 : color_q;
                    res_data.covered     = !oob_reg && (depth_q != zbtsc_pkg::DEPTH_MIN);
                    state_next           = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            init_reg  <= 1'b1;
            px_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            px_reg    <= px_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg   <= end_next;
        su_reg    <= su_next;
        sz_reg    <= sz_next;
        stepu_reg <= stepu_next;
        stepz_reg <= stepz_next;
        oob_reg   <= oob_next;
        inten_reg <= inten_next;
    end

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[addr] <= depth_wd;
        end
        depth_q <= depth_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[addr] <= color_wd;
        end
        color_q <= color_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (tex_we)
        begin
            tex_mem[cmd.index] <= cmd.texel;
        end
        tex_q <= tex_mem[tex_addr];
    end

    // no command leaves the queue while the reset clearing pass runs
    a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !cmd_pop)
        else $error("command taken during clearing pass");

    // a pixel write stays inside the column and before the segment end
    a_write_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PWR) |-> (px_reg < end_reg) && (px_reg < PXW'(COLUMN_HEIGHT)))
        else $error("pixel write outside span");

    // a stored pixel always raises the depth it replaces
    a_depth_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PWR) |-> (sz_reg > depth_q))
        else $error("pixel written without passing depth test");

    // a read result follows its memory access directly
    a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ROUT) |-> ($past(state_reg) == B_RRD || $past(state_reg) == B_ROUT))
        else $error("read result without memory access");

endmodule
`default_nettype wire

>>> sv/zbuffer_textured_span_column.sv
`timescale 1ns / 1ps
`default_nettype none
// One screen column with depth store, RGB565 colour store and a 256-texel texture row.
// Items enter through a queue-like port (push/full) and read results leave through
// another (empty/pop). A front part takes each item: draws are projected, clipped and
// given their per-row u and depth increments there by a 27-step restoring divider,
// other actions go straight to the command queue. A draw with no forward extent or
// one clipped away entirely is dropped, and full stays high while the front part
// works on an item. A two-entry queue feeds the back part, which owns the memories.
// Clear writes every row, load writes one texel, read reads the row and then returns
// its result, and a draw reads the depth of each row, tests it and writes only the
// rows that pass, a depth read-modify-write on one memory port.
// After reset a clearing pass over every row runs with full held high;
// configuration writes are always taken.
module zbuffer_textured_span_column #(
    parameter int COLUMN_HEIGHT = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire zbtsc_pkg::item_t   item,
    output logic                    empty,
    input  wire logic               pop,
    output zbtsc_pkg::result_t      result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [19:0]        cfg_data
);
    zbtsc_pkg::cfg_t    cfg_reg, cfg_next;
    zbtsc_pkg::cmd_t    front_cmd, back_cmd;
    zbtsc_pkg::result_t res_data;
    logic               cmd_valid, cmd_full, cmd_empty, cmd_pop;
    logic               res_push, res_full, init_busy;

    // register writes always complete in one transaction
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                zbtsc_pkg::CFG_CENTER_ROW: cfg_next.center_row       = cfg_data[7:0];
                zbtsc_pkg::CFG_SCALE_Q16:  cfg_next.scale_q16        = cfg_data;
                zbtsc_pkg::CFG_BACKGROUND: cfg_next.background_color = cfg_data[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_row       <= 8'd128;
            cfg_reg.scale_q16        <= 20'd65536;
            cfg_reg.background_color <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accepts and prepares items
    zbtsc_front #(
        .COLUMN_HEIGHT(COLUMN_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg       (cfg_reg),
        .init_busy (init_busy),
        .cmd_valid (cmd_valid),
        .cmd       (front_cmd),
        .cmd_full  (cmd_full)
    );

    // short command queue between the two halves
    zbtsc_fifo #(
        .T     (zbtsc_pkg::cmd_t),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    // back: memories and per-row sequencing
    zbtsc_back #(
        .COLUMN_HEIGHT(COLUMN_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd        (back_cmd),
        .cmd_pop    (cmd_pop),
        .background (cfg_reg.background_color),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_data),
        .init_busy  (init_busy)
    );

    // result queue decouples pop from the back part
    zbtsc_fifo #(
        .T     (zbtsc_pkg::result_t),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule
`default_nettype wire
